// ===== design/swm_pkg.sv =====
`default_nettype none

package swm_pkg;

  localparam int unsigned MAX_WINDOW_DEF  = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned CFG_BITS        = 5;
  localparam logic [CFG_BITS-1:0] WINDOW_RESET = 5'd3;

  typedef struct packed {
    logic step;
    logic full;
    logic clear;
  } ctrl_t;

  function automatic int unsigned eff_window(logic [CFG_BITS-1:0] wl, int unsigned max_w);
    int unsigned w;
    w = int'(wl);
    if (w == 0) begin
      return 1;
    end
    if (w > max_w) begin
      return max_w;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/swm_sample_if.sv =====
`default_nettype none

interface swm_sample_if #(
  parameter int unsigned SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== design/swm_result_if.sv =====
`default_nettype none

interface swm_result_if #(
  parameter int unsigned SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] median_doubled;

  modport source (output valid, output median_doubled, input ready);
  modport sink   (input valid, input median_doubled, output ready);
endinterface

`default_nettype wire

// ===== design/sliding_window_median.sv =====
// The result of an accepted sample is registered and valid on the next cycle.
// Throughput: one sample per cycle unless result_o stalls; each chain cell drops
// the oldest entry if full and inserts the sample in one compare-and-shift step.
// Reset: window length 3, chain empty. A window write empties the chain likewise.
`default_nettype none

module sliding_window_median #(
  parameter int unsigned MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [swm_pkg::CFG_BITS-1:0]  cfg_data_i,
  swm_sample_if.sink                   sample_i,
  swm_result_if.source                 result_o
);

  localparam int unsigned CNT_BITS = $clog2(MAX_WINDOW + 1);
  localparam int unsigned AGE_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [CNT_BITS-1:0] win_q, fill_q, fill_new, lo_idx, hi_idx;
  logic                full, step, out_valid_q;
  logic signed [SAMPLE_BITS:0] median_q;
  logic signed [SAMPLE_BITS-1:0] lo_val, hi_val;
  logic [AGE_BITS-1:0] last_age;
  swm_pkg::ctrl_t ctrl;

  logic signed [SAMPLE_BITS-1:0] value  [MAX_WINDOW];
  logic        [AGE_BITS-1:0]    age    [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] ap_val [MAX_WINDOW];
  logic        [AGE_BITS-1:0]    ap_age [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] nxt    [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] valid_vec, ap_valid, ap_le, evict;

  assign sample_i.ready        = !out_valid_q || result_o.ready;
  assign step                  = sample_i.valid && sample_i.ready;
  assign full                  = (fill_q == win_q);
  assign last_age              = AGE_BITS'(win_q - CNT_BITS'(1));
  assign ctrl.step             = step;
  assign ctrl.full             = full;
  assign ctrl.clear            = cfg_we_i;
  assign fill_new              = full ? fill_q : fill_q + CNT_BITS'(1);
  assign lo_idx                = (fill_new - CNT_BITS'(1)) >> 1;
  assign hi_idx                = fill_new >> 1;
  assign result_o.valid        = out_valid_q;
  assign result_o.median_doubled = median_q;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] l_val, r_val;
    logic        [AGE_BITS-1:0]    l_age, r_age;
    logic                          l_valid, l_le, l_ev, r_valid;

    if (i == 0) begin : g_head
      assign l_val   = '0;
      assign l_age   = '0;
      assign l_valid = 1'b1;
      assign l_le    = 1'b1;
      assign l_ev    = 1'b0;
    end else begin : g_link
      assign l_val   = ap_val[i-1];
      assign l_age   = ap_age[i-1];
      assign l_valid = ap_valid[i-1];
      assign l_le    = ap_le[i-1];
      assign l_ev    = evict[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_tail
      assign r_val   = '0;
      assign r_age   = '0;
      assign r_valid = 1'b0;
    end else begin : g_next
      assign r_val   = value[i+1];
      assign r_age   = age[i+1];
      assign r_valid = valid_vec[i+1];
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_BITS    (AGE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .sample_i      (sample_i.sample),
      .last_age_i    (last_age),
      .left_value_i  (l_val),
      .left_age_i    (l_age),
      .left_valid_i  (l_valid),
      .left_le_i     (l_le),
      .left_evict_i  (l_ev),
      .right_value_i (r_val),
      .right_age_i   (r_age),
      .right_valid_i (r_valid),
      .value_o       (value[i]),
      .age_o         (age[i]),
      .valid_o       (valid_vec[i]),
      .ap_value_o    (ap_val[i]),
      .ap_age_o      (ap_age[i]),
      .ap_valid_o    (ap_valid[i]),
      .ap_le_o       (ap_le[i]),
      .evict_o       (evict[i]),
      .nxt_value_o   (nxt[i])
    );
  end

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (lo_idx == CNT_BITS'(i)) begin
        lo_val = lo_val | nxt[i];
      end
      if (hi_idx == CNT_BITS'(i)) begin
        hi_val = hi_val | nxt[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= CNT_BITS'(swm_pkg::eff_window(swm_pkg::WINDOW_RESET, MAX_WINDOW));
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q  <= CNT_BITS'(swm_pkg::eff_window(cfg_data_i, MAX_WINDOW));
        fill_q <= '0;
      end else if (step) begin
        fill_q <= fill_new;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      median_q <= {lo_val[SAMPLE_BITS-1], lo_val} + {hi_val[SAMPLE_BITS-1], hi_val};
    end
  end

  logic sorted_ok;
  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 0; i < MAX_WINDOW - 1; i++) begin
      if (valid_vec[i+1] && (value[i] > value[i+1])) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= win_q) else $error("fill count above window");

  a_fill_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(fill_q)) else $error("valid cells disagree with fill count");

  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & MAX_WINDOW'(valid_vec + MAX_WINDOW'(1))) == '0)
    else $error("valid cells not contiguous");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sorted_ok) else $error("chain out of order");

  a_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && full) |-> evict[MAX_WINDOW-1]) else $error("no oldest entry found");

  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q) else $error("accepted word produced no result");

endmodule

`default_nettype wire

// ===== design/swm_cell.sv =====
`default_nettype none

module swm_cell #(
  parameter int unsigned SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned AGE_BITS    = 4
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire swm_pkg::ctrl_t          ctrl_i,
  input  wire signed [SAMPLE_BITS-1:0] sample_i,
  input  wire        [AGE_BITS-1:0]    last_age_i,
  input  wire signed [SAMPLE_BITS-1:0] left_value_i,
  input  wire        [AGE_BITS-1:0]    left_age_i,
  input  wire                          left_valid_i,
  input  wire                          left_le_i,
  input  wire                          left_evict_i,
  input  wire signed [SAMPLE_BITS-1:0] right_value_i,
  input  wire        [AGE_BITS-1:0]    right_age_i,
  input  wire                          right_valid_i,
  output logic signed [SAMPLE_BITS-1:0] value_o,
  output logic        [AGE_BITS-1:0]    age_o,
  output logic                          valid_o,
  output logic signed [SAMPLE_BITS-1:0] ap_value_o,
  output logic        [AGE_BITS-1:0]    ap_age_o,
  output logic                          ap_valid_o,
  output logic                          ap_le_o,
  output logic                          evict_o,
  output logic signed [SAMPLE_BITS-1:0] nxt_value_o
);

  logic signed [SAMPLE_BITS-1:0] value_q, value_d;
  logic        [AGE_BITS-1:0]    age_q, age_d;
  logic                          valid_q, valid_d;
  logic                          own_evict;

  assign own_evict  = ctrl_i.full && valid_q && (age_q == last_age_i);
  assign evict_o    = left_evict_i | own_evict;
  assign ap_value_o = evict_o ? right_value_i : value_q;
  assign ap_age_o   = evict_o ? right_age_i   : age_q;
  assign ap_valid_o = evict_o ? right_valid_i : valid_q;
  assign ap_le_o    = ap_valid_o && (ap_value_o <= sample_i);

  // insert below the first entry greater than the new word
  always_comb begin
    if (ap_le_o) begin
      value_d = ap_value_o;
      age_d   = ap_age_o + AGE_BITS'(1);
      valid_d = ap_valid_o;
    end else if (left_le_i) begin
      value_d = sample_i;
      age_d   = '0;
      valid_d = 1'b1;
    end else begin
      value_d = left_value_i;
      age_d   = left_age_i + AGE_BITS'(1);
      valid_d = left_valid_i;
    end
  end

  assign nxt_value_o = value_d;
  assign value_o     = value_q;
  assign age_o       = age_q;
  assign valid_o     = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.step) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      value_q <= value_d;
      age_q   <= age_d;
    end
  end

endmodule

`default_nettype wire
